FILE: rtl/core/wmmf_pkg.sv
package wmmf_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WCNT_W    = 11;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 10;
  localparam int PIX_W     = 8;

  // Output queue.
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Register map (word index = paddr[3:2]).
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [WCNT_W-1:0] WIDTH_RESET  = WCNT_W'(1024);
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(3);
  localparam logic              MODE_MEAN    = 1'b0;
  localparam logic              MODE_MEDIAN  = 1'b1;

  // floor(x / 9) = (x * RECIP9) >> 16 for all x below about 30000.
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int RECIP_SH   = 16;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } trio_t;

  // Side information carried alongside a pixel through the pipeline.
  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  typedef struct packed {
    pix_t             pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } out_word_t;

  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t  x;
    pix_t  y;
    pix_t  z;
    pix_t  t;
    trio_t res;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    res.lo  = x;
    res.mid = y;
    res.hi  = z;
    return res;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    trio_t s;
    s = sort3(a, b, c);
    return s.mid;
  endfunction

endpackage

FILE: rtl/core/window3x3_mean_median_filter_top.sv
// 3x3 mean or median filter over a raster stream of 8-bit grey pixels. The block accepts one
// pixel per clock cycle sustained while in_ready is high; each pixel does one read and one
// write-back on each of the two simple dual-port line stores, and the next pixel always
// addresses the next column, so no interlock is needed. A result for the window centred one
// row and one column back passes through the pipeline registers into the output queue, and
// border pixels give no result. Results wait in an eight-word output queue; in_ready falls
// only when the queue and the four pipeline stages together hold eight words. The line stores
// need no clearing pass: entries are read before they are written only while the first two
// rows of a frame come in, and those windows are never emitted. Write the registers only
// while the block is idle; a write to image_width or image_height restarts the frame.
module window3x3_mean_median_filter_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [wmmf_pkg::PIX_W-1:0]            in_pixel_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [wmmf_pkg::PIX_W-1:0]            out_pixel_out,
  output logic [wmmf_pkg::ROW_W-1:0]            out_centre_row,
  output logic [wmmf_pkg::COL_W-1:0]            out_centre_col,
  output logic                                  out_frame_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wmmf_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // Configuration registers.
  logic                         mode_r;
  logic [wmmf_pkg::WCNT_W-1:0]  width_r;
  logic [wmmf_pkg::ROW_W-1:0]   height_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      wmmf_pkg::REG_MODE:   prdata = {31'd0, mode_r};
      wmmf_pkg::REG_WIDTH:  prdata = {{(32 - wmmf_pkg::WCNT_W){1'b0}}, width_r};
      wmmf_pkg::REG_HEIGHT: prdata = {{(32 - wmmf_pkg::ROW_W){1'b0}}, height_r};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= wmmf_pkg::MODE_MEAN;
      width_r  <= wmmf_pkg::WIDTH_RESET;
      height_r <= wmmf_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wmmf_pkg::REG_MODE:   mode_r   <= pwdata[0];
        wmmf_pkg::REG_WIDTH:  width_r  <= pwdata[wmmf_pkg::WCNT_W-1:0];
        wmmf_pkg::REG_HEIGHT: height_r <= pwdata[wmmf_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [wmmf_pkg::WCNT_W-1:0] w_eff;
  logic [wmmf_pkg::ROW_W-1:0]  h_eff;

  always_comb begin
    if (width_r < wmmf_pkg::WCNT_W'(3)) begin
      w_eff = wmmf_pkg::WCNT_W'(3);
    end else if (width_r > wmmf_pkg::WCNT_W'(wmmf_pkg::MAX_WIDTH)) begin
      w_eff = wmmf_pkg::WCNT_W'(wmmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < wmmf_pkg::ROW_W'(3)) ? wmmf_pkg::ROW_W'(3) : height_r;
  end

  // Pipeline valid bits and queue bookkeeping.
  logic                        v1_r, v2_r, v3_r, v4_r;
  logic [wmmf_pkg::QCNT_W-1:0] q_cnt_r;
  logic [wmmf_pkg::QPTR_W-1:0] q_wr_r, q_rd_r;
  logic [wmmf_pkg::QCNT_W:0]   occupancy;
  logic                        in_acc;
  logic                        push, pop;

  assign occupancy = (wmmf_pkg::QCNT_W + 1)'(q_cnt_r)
                   + (wmmf_pkg::QCNT_W + 1)'(v1_r) + (wmmf_pkg::QCNT_W + 1)'(v2_r)
                   + (wmmf_pkg::QCNT_W + 1)'(v3_r) + (wmmf_pkg::QCNT_W + 1)'(v4_r);
  assign in_ready  = occupancy < (wmmf_pkg::QCNT_W + 1)'(wmmf_pkg::QDEPTH);
  assign in_acc    = in_valid && in_ready;

  // Stage 0: position counters and line store reads.
  logic [wmmf_pkg::ADDR_W-1:0] col_r, col_nxt, cc;
  logic [wmmf_pkg::ROW_W-1:0]  row_r, row_nxt, rc;
  logic [wmmf_pkg::WCNT_W-1:0] col_inc;
  wmmf_pkg::meta_t             meta0;

  always_comb begin
    cc = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    rc = (row_r >= h_eff) ? '0 : row_r;
    col_inc = {1'b0, cc} + wmmf_pkg::WCNT_W'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (rc + wmmf_pkg::ROW_W'(1) >= h_eff) ? '0 : rc + wmmf_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_inc[wmmf_pkg::ADDR_W-1:0];
      row_nxt = rc;
    end
    meta0.emit = (rc >= wmmf_pkg::ROW_W'(2)) && (cc >= wmmf_pkg::ADDR_W'(2));
    meta0.row  = rc - wmmf_pkg::ROW_W'(1);
    meta0.col  = wmmf_pkg::COL_W'(cc - wmmf_pkg::ADDR_W'(1));
    meta0.last = (rc == h_eff - wmmf_pkg::ROW_W'(1))
              && ({1'b0, cc} == w_eff - wmmf_pkg::WCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr && (cfg_idx == wmmf_pkg::REG_WIDTH || cfg_idx == wmmf_pkg::REG_HEIGHT))
    begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  logic [wmmf_pkg::PIX_W-1:0]  upper_mem  [wmmf_pkg::MAX_WIDTH];
  logic [wmmf_pkg::PIX_W-1:0]  middle_mem [wmmf_pkg::MAX_WIDTH];
  wmmf_pkg::pix_t              top_rd_r, mid_rd_r, pix1_r;
  logic [wmmf_pkg::ADDR_W-1:0] addr1_r;
  wmmf_pkg::meta_t             meta1_r, meta2_r, meta3_r, meta4_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_rd_r <= upper_mem[cc];
      mid_rd_r <= middle_mem[cc];
      pix1_r   <= in_pixel_in;
      addr1_r  <= cc;
      meta1_r  <= meta0;
    end
  end

  // Stage 1: write back the shifted column. The next pixel reads the next column,
  // so this write never meets a read of the same entry.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      upper_mem[addr1_r]  <= mid_rd_r;
      middle_mem[addr1_r] <= pix1_r;
    end
  end

  wmmf_pkg::pix_t window_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        window_r[k] <= '0;
      end
    end else if (v1_r) begin
      window_r[0] <= window_r[1];
      window_r[1] <= window_r[2];
      window_r[2] <= top_rd_r;
      window_r[3] <= window_r[4];
      window_r[4] <= window_r[5];
      window_r[5] <= mid_rd_r;
      window_r[6] <= window_r[7];
      window_r[7] <= window_r[8];
      window_r[8] <= pix1_r;
    end
  end

  // Stage 2: sort each row and form row sums.
  wmmf_pkg::trio_t             srt_a_r, srt_b_r, srt_c_r;
  logic [wmmf_pkg::PIX_W+1:0]  rsum_a_r, rsum_b_r, rsum_c_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      srt_a_r  <= wmmf_pkg::sort3(window_r[0], window_r[1], window_r[2]);
      srt_b_r  <= wmmf_pkg::sort3(window_r[3], window_r[4], window_r[5]);
      srt_c_r  <= wmmf_pkg::sort3(window_r[6], window_r[7], window_r[8]);
      rsum_a_r <= (wmmf_pkg::PIX_W + 2)'(window_r[0]) + (wmmf_pkg::PIX_W + 2)'(window_r[1])
                + (wmmf_pkg::PIX_W + 2)'(window_r[2]);
      rsum_b_r <= (wmmf_pkg::PIX_W + 2)'(window_r[3]) + (wmmf_pkg::PIX_W + 2)'(window_r[4])
                + (wmmf_pkg::PIX_W + 2)'(window_r[5]);
      rsum_c_r <= (wmmf_pkg::PIX_W + 2)'(window_r[6]) + (wmmf_pkg::PIX_W + 2)'(window_r[7])
                + (wmmf_pkg::PIX_W + 2)'(window_r[8]);
    end
  end

  // Stage 3: the median of nine is the median of the largest low, the middle
  // median and the smallest high of the sorted rows.
  wmmf_pkg::pix_t              mx_lo_r, md_md_r, mn_hi_r;
  logic [wmmf_pkg::SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (v3_r) begin
      mx_lo_r <= wmmf_pkg::max3(srt_a_r.lo, srt_b_r.lo, srt_c_r.lo);
      md_md_r <= wmmf_pkg::med3(srt_a_r.mid, srt_b_r.mid, srt_c_r.mid);
      mn_hi_r <= wmmf_pkg::min3(srt_a_r.hi, srt_b_r.hi, srt_c_r.hi);
      sum_r   <= wmmf_pkg::SUM_W'(rsum_a_r) + wmmf_pkg::SUM_W'(rsum_b_r)
               + wmmf_pkg::SUM_W'(rsum_c_r);
    end
  end

  // Stage 4: final selection, written into the output queue.
  logic [wmmf_pkg::PROD_W-1:0] prod;
  wmmf_pkg::pix_t              mean_val, median_val;
  wmmf_pkg::out_word_t         res_word;

  always_comb begin
    prod           = wmmf_pkg::PROD_W'(sum_r) * wmmf_pkg::PROD_W'(wmmf_pkg::RECIP9);
    mean_val       = prod[wmmf_pkg::RECIP_SH +: wmmf_pkg::PIX_W];
    median_val     = wmmf_pkg::med3(mx_lo_r, md_md_r, mn_hi_r);
    res_word.pixel = (mode_r == wmmf_pkg::MODE_MEDIAN) ? median_val : mean_val;
    res_word.row   = meta4_r.row;
    res_word.col   = meta4_r.col;
    res_word.last  = meta4_r.last;
  end

  always_ff @(posedge clk) begin
    meta2_r <= meta1_r;
    meta3_r <= meta2_r;
    meta4_r <= meta3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Output queue.
  wmmf_pkg::out_word_t queue_r [wmmf_pkg::QDEPTH];
  wmmf_pkg::out_word_t head;

  assign push      = v4_r && meta4_r.emit;
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = queue_r[q_rd_r];

  assign out_pixel_out  = head.pixel;
  assign out_centre_row = head.row;
  assign out_centre_col = head.col;
  assign out_frame_last = head.last;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[q_wr_r] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
    end else begin
      if (push) begin
        q_wr_r <= q_wr_r + wmmf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + wmmf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + wmmf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - wmmf_pkg::QCNT_W'(1);
      end
    end
  end

  // The queue must never be pushed while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_cnt_r < wmmf_pkg::QCNT_W'(wmmf_pkg::QDEPTH) || pop))
    else $error("output queue overflow");

  // Words in flight plus queued words stay within the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (wmmf_pkg::QCNT_W + 1)'(wmmf_pkg::QDEPTH))
    else $error("credit count exceeds queue depth");

  // A line store write-back never hits the entry being read in the same cycle.
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && in_acc) |-> (addr1_r != cc))
    else $error("line store read and write-back address clash");

  // Every accepted pixel reaches the last stage without a stall.
  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##4 v4_r)
    else $error("pipeline lost a word");

endmodule

FILE: dv/window3x3_mean_median_filter_top_test.sv
`timescale 1ns / 1ps

module window3x3_mean_median_filter_top_test;

  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 16;
  localparam int RANDOM_WORDS = 250;

  typedef enum {PIX_RANDOM, PIX_NARROW, PIX_EXTREME, PIX_RAMP} pixel_style_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [wmmf_pkg::PIX_W-1:0]    in_pixel_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [wmmf_pkg::PIX_W-1:0]    out_pixel_out;
  logic [wmmf_pkg::ROW_W-1:0]    out_centre_row;
  logic [wmmf_pkg::COL_W-1:0]    out_centre_col;
  logic                          out_frame_last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [wmmf_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Shadow copy of the filter state.
  wmmf_pkg::pix_t                upper_row [wmmf_pkg::MAX_WIDTH];
  wmmf_pkg::pix_t                middle_row [wmmf_pkg::MAX_WIDTH];
  wmmf_pkg::pix_t                window [9];
  int unsigned                   col_cnt;
  int unsigned                   row_cnt;
  logic                          mode_q;
  logic [wmmf_pkg::WCNT_W-1:0]   width_q;
  logic [wmmf_pkg::ROW_W-1:0]    height_q;

  wmmf_pkg::out_word_t           pending_windows [$];
  wmmf_pkg::out_word_t           want_word;
  int                            mismatch_count = 0;
  int                            pixels_sent;
  int                            quiet_cycles = 0;
  bit                            tx_steady;
  bit                            rx_steady;
  wmmf_pkg::pix_t                pixel_base;

  window3x3_mean_median_filter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_centre_row (out_centre_row),
    .out_centre_col (out_centre_col),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned cols_in_use();
    if (width_q < 3) return 3;
    if (width_q > wmmf_pkg::MAX_WIDTH) return wmmf_pkg::MAX_WIDTH;
    return 32'(width_q);
  endfunction

  function automatic int unsigned rows_in_use();
    if (height_q < 3) return 3;
    return 32'(height_q);
  endfunction

  // Shifts one pixel through the line stores and the window; queues a result
  // once the window around an interior pixel is complete.
  task automatic slide_window(input wmmf_pkg::pix_t p);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    wmmf_pkg::pix_t      top;
    wmmf_pkg::pix_t      mid;
    int                  sum;
    int                  below;
    int                  not_above;
    wmmf_pkg::out_word_t res;
    w = cols_in_use();
    h = rows_in_use();
    c = (col_cnt >= w) ? 0 : col_cnt;
    r = (row_cnt >= h) ? 0 : row_cnt;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = p;
    for (int k = 0; k < 2; k++) begin
      window[k] = window[k+1];
      window[k+3] = window[k+4];
      window[k+6] = window[k+7];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = p;
    if (r >= 2 && c >= 2) begin
      if (mode_q == wmmf_pkg::MODE_MEDIAN) begin
        // The median is the value with at most four smaller and at least
        // five not larger.
        res.pixel = '0;
        for (int i = 0; i < 9; i++) begin
          below = 0;
          not_above = 0;
          for (int j = 0; j < 9; j++) begin
            if (window[j] < window[i]) below++;
            if (window[j] <= window[i]) not_above++;
          end
          if (below <= 4 && not_above >= 5) res.pixel = window[i];
        end
      end else begin
        sum = 0;
        for (int i = 0; i < 9; i++) sum += window[i];
        res.pixel = wmmf_pkg::PIX_W'(sum / 9);
      end
      res.row = wmmf_pkg::ROW_W'(r - 1);
      res.col = wmmf_pkg::COL_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      pending_windows.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic send_pixel(input wmmf_pkg::pix_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slide_window(p);
    pixels_sent++;
  endtask

  function automatic wmmf_pkg::pix_t make_pixel(input pixel_style_t style, input int k);
    case (style)
      PIX_NARROW:  return pixel_base + wmmf_pkg::PIX_W'($urandom_range(0, 7));
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_RAMP:    return wmmf_pkg::PIX_W'(k * 37 + pixel_base);
      default:     return wmmf_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixels(input int first, input int stop, input pixel_style_t style);
    for (int k = first; k < stop; k++) send_pixel(make_pixel(style, k));
  endtask

  // Holds the input off until every expected word is out, then lets the
  // pipeline settle so that pixels with no result are flushed too.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      wmmf_pkg::REG_MODE: mode_q = data[0];
      wmmf_pkg::REG_WIDTH: begin
        width_q = data[wmmf_pkg::WCNT_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      wmmf_pkg::REG_HEIGHT: begin
        height_q = data[wmmf_pkg::ROW_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(input logic mode, input logic [31:0] cols,
                              input logic [31:0] rows);
    drain_pipeline();
    cfg_write(wmmf_pkg::REG_MODE, 32'(mode));
    cfg_write(wmmf_pkg::REG_WIDTH, cols);
    cfg_write(wmmf_pkg::REG_HEIGHT, rows);
  endtask

  // Three 3x3 frames, the pipeline drained between them: saturated mean, a mixed
  // median, and a black mean frame after the counters wrap.
  task automatic test_extreme_windows();
    wmmf_pkg::pix_t mixed [9] = '{8'd200, 8'd13, 8'd255, 8'd0, 8'd77, 8'd77, 8'd150, 8'd9,
                                  8'd128};
    set_geometry(wmmf_pkg::MODE_MEAN, 3, 3);
    repeat (9) send_pixel(8'hFF);
    set_geometry(wmmf_pkg::MODE_MEDIAN, 3, 3);
    foreach (mixed[i]) send_pixel(mixed[i]);
    drain_pipeline();
    cfg_write(wmmf_pkg::REG_MODE, 32'(wmmf_pkg::MODE_MEAN));
    repeat (9) send_pixel(8'h00);
  endtask

  // Out-of-range geometry is clamped; upper register bits are ignored.
  task automatic test_geometry_clamps();
    set_geometry(wmmf_pkg::MODE_MEDIAN, 0, 0);
    send_pixels(0, 18, PIX_RANDOM);
    set_geometry(wmmf_pkg::MODE_MEAN, 2, 32'hFFFF_FFFF);
    send_pixels(0, 120, PIX_EXTREME);
  endtask

  // The widest frame is cut short just past its first row: it checks the width
  // clamp and the column wrap, where no word may come out yet.
  task automatic test_widest_frame();
    set_geometry(1'($urandom_range(0, 1)), 32'hFFFF_FFFF, 3);
    send_pixels(0, cols_in_use() + 16, PIX_RANDOM);
  endtask

  task automatic test_random_frames();
    int           start;
    logic         mode;
    int           wreg;
    int           hreg;
    int           total;
    int           left;
    int           split;
    int           plan;
    pixel_style_t style;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_WORDS) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       wreg = $urandom_range(0, 2);
        1:       wreg = $urandom_range(41, 90);
        default: wreg = $urandom_range(3, 14);
      endcase
      case ($urandom_range(0, 9))
        0:       hreg = $urandom_range(0, 2);
        1:       hreg = $urandom_range(9, 14);
        default: hreg = $urandom_range(3, 7);
      endcase
      set_geometry(mode, wreg, hreg);
      tx_steady = ($urandom_range(0, 3) == 0);
      style = pixel_style_t'($urandom_range(0, 3));
      pixel_base = wmmf_pkg::PIX_W'($urandom_range(0, 255));
      total = cols_in_use() * rows_in_use();
      if (cols_in_use() <= 14) total = total * $urandom_range(1, 3);
      // Keep the last frames within the budget of words.
      left = RANDOM_WORDS - (pixels_sent - start);
      if (total > left) total = left;
      if (total < 2) total = 2;
      plan = $urandom_range(0, 9);
      split = $urandom_range(1, total - 1);
      if (plan < 2) begin
        // Broken frame: the next geometry write restarts it.
        send_pixels(0, split, style);
      end else if (plan < 5) begin
        // Pause mid-frame until the output is empty, maybe flipping the mode.
        send_pixels(0, split, style);
        drain_pipeline();
        if ($urandom_range(0, 1)) cfg_write(wmmf_pkg::REG_MODE, 32'(~mode));
        send_pixels(split, total, style);
      end else begin
        send_pixels(0, total, style);
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < wmmf_pkg::MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    mode_q = wmmf_pkg::MODE_MEAN;
    width_q = wmmf_pkg::WIDTH_RESET;
    height_q = wmmf_pkg::HEIGHT_RESET;
    pixels_sent = 0;
    tx_steady = 1'b0;
    pixel_base = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extreme_windows();
    test_geometry_clamps();
    test_widest_frame();
    test_random_frames();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("window3x3_mean_median_filter_top_test: done, clean");
    end else begin
      $display("window3x3_mean_median_filter_top_test: done, errors");
    end
    $finish;
  end

  // Result side: a random stall before taking each word, with runs of none.
  initial begin
    int stall;
    rx_steady = 1'b0;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pixel %0d row %0d col %0d last %0d",
                 $time, out_pixel_out, out_centre_row, out_centre_col, out_frame_last);
        mismatch_count++;
      end else begin
        want_word = pending_windows.pop_front();
        check_field("pixel_out", want_word.pixel, out_pixel_out);
        check_field("centre_row", want_word.row, out_centre_row);
        check_field("centre_col", want_word.col, out_centre_col);
        check_field("frame_last", want_word.last, out_frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("window3x3_mean_median_filter_top_test: done, errors");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/core/wmmf_pkg.sv
rtl/core/window3x3_mean_median_filter_top.sv
dv/window3x3_mean_median_filter_top_test.sv
